// ===== sv/assert_macros.svh =====
// Concurrent assertion helpers, clocked and disabled while reset is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds at every clock edge
`define ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error(msg);

// pre at one edge implies post at the next
`define ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== sv/rag_pkg.sv =====
package rag_pkg;

  localparam int FIELD_W = 32;
  localparam int FUNC_W  = 3;

  localparam logic [FUNC_W-1:0] FUNC_LOAD    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_MUL_ACC = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_ADD_ACC = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_MUL_AB  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_ADD_AB  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_DONE
  } st_e;

endpackage

// ===== sv/rag_in_if.sv =====
interface rag_in_if;
  logic                                valid;
  logic                                ready;
  logic        [rag_pkg::FUNC_W-1:0]   func;
  logic signed [rag_pkg::FIELD_W-1:0]  a_num;
  logic signed [rag_pkg::FIELD_W-1:0]  a_den;
  logic signed [rag_pkg::FIELD_W-1:0]  b_num;
  logic signed [rag_pkg::FIELD_W-1:0]  b_den;

  modport source (output valid, func, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, func, a_num, a_den, b_num, b_den, output ready);
endinterface

// ===== sv/rag_out_if.sv =====
interface rag_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rag_pkg::FIELD_W-1:0]  res_num;
  logic signed [rag_pkg::FIELD_W-1:0]  res_den;
  logic                                overflow;

  modport source (output valid, res_num, res_den, overflow, input ready);
  modport sink   (input valid, res_num, res_den, overflow, output ready);
endinterface

// ===== sv/rational_arith_gcd_reduce.sv =====
// Rational accumulator, reduced by Euclid gcd after every arithmetic beat.
// One shift-add/subtract unit does each product, remainder and quotient.
// Arithmetic beat: 2 products for multiply codes or 3 for add codes, then Euclid steps.
// Load and unused codes go straight to the result. One beat at a time.
// Reset (asynchronous, active low) sets the fraction to 0/1 and empties the output.
`include "assert_macros.svh"

module rational_arith_gcd_reduce #(
  parameter int WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rag_in_if.sink    in_i,
  rag_out_if.source out_o
);

  localparam int FW = rag_pkg::FIELD_W;
  localparam int CW = $clog2(WIDTH + 2);
  localparam logic [CW-1:0] CntLast = CW'(WIDTH + 1);

  rag_pkg::st_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [rag_pkg::FUNC_W-1:0] func_q;
  logic [WIDTH-1:0] an_q, ad_q, bn_q, bd_q;
  logic [WIDTH-1:0] acc_num_q, acc_num_d, acc_den_q, acc_den_d;
  logic [WIDTH-1:0] n_q, n_d, d_q, d_d;
  logic [WIDTH-1:0] hi_q, hi_d, lo_q, lo_d, y_q, y_d;
  logic [WIDTH-1:0] ga_q, ga_d, gb_q, gb_d;
  logic gsa_q, gsa_d, gsb_q, gsb_d;
  logic neg_q, neg_d, ov_q, ov_d;

  logic [WIDTH-1:0] an_w, ad_w, bn_w, bd_w, ad_fix, bd_fix;
  logic [WIDTH-1:0] mul_x, mul_y;
  logic [WIDTH-1:0] trial, hi_step, lo_step;
  logic [WIDTH:0]   add_a, add_b, sum;
  logic [WIDTH-1:0] prod_val, sum2;
  logic is_mul, prod_ov, add_ov, accept;

  function automatic logic [WIDTH-1:0] mag(input logic [WIDTH-1:0] v);
    return v[WIDTH-1] ? (~v + WIDTH'(1)) : v;
  endfunction

  function automatic logic [WIDTH-1:0] apply_sign(input logic [WIDTH-1:0] m, input logic neg);
    return neg ? (~m + WIDTH'(1)) : m;
  endfunction

  assign an_w   = WIDTH'($signed(in_i.a_num));
  assign ad_w   = WIDTH'($signed(in_i.a_den));
  assign bn_w   = WIDTH'($signed(in_i.b_num));
  assign bd_w   = WIDTH'($signed(in_i.b_den));
  assign ad_fix = (ad_w == '0) ? {{(WIDTH-1){1'b0}}, 1'b1} : ad_w;
  assign bd_fix = (bd_w == '0) ? {{(WIDTH-1){1'b0}}, 1'b1} : bd_w;

  assign accept = in_i.valid && in_i.ready;

  // operand pair for the product in hand
  always_comb begin
    mul_x = an_q;
    mul_y = bd_q;
    case (state_q)
      rag_pkg::ST_MUL0: begin
        if (func_q == rag_pkg::FUNC_MUL_ACC) begin
          mul_x = acc_num_q;
          mul_y = an_q;
        end else if (func_q == rag_pkg::FUNC_ADD_ACC) begin
          mul_x = acc_num_q;
          mul_y = ad_q;
        end else if (func_q == rag_pkg::FUNC_MUL_AB) begin
          mul_x = an_q;
          mul_y = bn_q;
        end else begin
          mul_x = an_q;
          mul_y = bd_q;
        end
      end
      rag_pkg::ST_MUL1: begin
        if (func_q == rag_pkg::FUNC_ADD_ACC) begin
          mul_x = an_q;
          mul_y = acc_den_q;
        end else begin
          mul_x = bn_q;
          mul_y = ad_q;
        end
      end
      rag_pkg::ST_MUL2: begin
        if (func_q == rag_pkg::FUNC_MUL_ACC || func_q == rag_pkg::FUNC_ADD_ACC) begin
          mul_x = acc_den_q;
          mul_y = ad_q;
        end else begin
          mul_x = ad_q;
          mul_y = bd_q;
        end
      end
      default: begin
        mul_x = an_q;
        mul_y = bd_q;
      end
    endcase
  end

  // shared adder: shift-add for products, shift-subtract for division
  assign is_mul = (state_q == rag_pkg::ST_MUL0) || (state_q == rag_pkg::ST_MUL1) ||
                  (state_q == rag_pkg::ST_MUL2);
  assign trial  = {hi_q[WIDTH-2:0], lo_q[WIDTH-1]};
  assign add_a  = is_mul ? {1'b0, hi_q} : {1'b0, trial};
  assign add_b  = is_mul ? (lo_q[0] ? {1'b0, y_q} : '0) : ~{1'b0, y_q};
  assign sum    = add_a + add_b + {{WIDTH{1'b0}}, ~is_mul};

  always_comb begin
    if (is_mul) begin
      hi_step = sum[WIDTH:1];
      lo_step = {sum[0], lo_q[WIDTH-1:1]};
    end else if (!sum[WIDTH]) begin
      hi_step = sum[WIDTH-1:0];
      lo_step = {lo_q[WIDTH-2:0], 1'b1};
    end else begin
      hi_step = trial;
      lo_step = {lo_q[WIDTH-2:0], 1'b0};
    end
  end

  assign prod_val = apply_sign(lo_q, neg_q);
  assign prod_ov  = (|hi_q) || (lo_q[WIDTH-1] && (!neg_q || (|lo_q[WIDTH-2:0])));
  assign sum2     = n_q + prod_val;
  assign add_ov   = (n_q[WIDTH-1] == prod_val[WIDTH-1]) && (sum2[WIDTH-1] != n_q[WIDTH-1]);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    acc_num_d = acc_num_q;
    acc_den_d = acc_den_q;
    n_d       = n_q;
    d_d       = d_q;
    hi_d      = hi_q;
    lo_d      = lo_q;
    y_d       = y_q;
    neg_d     = neg_q;
    ga_d      = ga_q;
    gb_d      = gb_q;
    gsa_d     = gsa_q;
    gsb_d     = gsb_q;
    ov_d      = ov_q;

    case (state_q)
      rag_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          ov_d  = 1'b0;
          cnt_d = '0;
          if (in_i.func == rag_pkg::FUNC_LOAD) begin
            acc_num_d = an_w;
            acc_den_d = ad_fix;
            state_d   = rag_pkg::ST_DONE;
          end else if (in_i.func == rag_pkg::FUNC_MUL_ACC ||
                       in_i.func == rag_pkg::FUNC_ADD_ACC ||
                       in_i.func == rag_pkg::FUNC_MUL_AB ||
                       in_i.func == rag_pkg::FUNC_ADD_AB) begin
            state_d = rag_pkg::ST_MUL0;
          end else begin
            state_d = rag_pkg::ST_DONE;
          end
        end
      end
      rag_pkg::ST_MUL0, rag_pkg::ST_MUL1, rag_pkg::ST_MUL2: begin
        if (cnt_q == '0) begin
          hi_d  = '0;
          lo_d  = mag(mul_x);
          y_d   = mag(mul_y);
          neg_d = mul_x[WIDTH-1] ^ mul_y[WIDTH-1];
          cnt_d = cnt_q + CW'(1);
        end else if (cnt_q != CntLast) begin
          hi_d  = hi_step;
          lo_d  = lo_step;
          cnt_d = cnt_q + CW'(1);
        end else begin
          cnt_d = '0;
          ov_d  = ov_q | prod_ov;
          if (state_q == rag_pkg::ST_MUL0) begin
            n_d = prod_val;
            if (func_q == rag_pkg::FUNC_ADD_ACC || func_q == rag_pkg::FUNC_ADD_AB) begin
              state_d = rag_pkg::ST_MUL1;
            end else begin
              state_d = rag_pkg::ST_MUL2;
            end
          end else if (state_q == rag_pkg::ST_MUL1) begin
            n_d     = sum2;
            ov_d    = ov_q | prod_ov | add_ov;
            state_d = rag_pkg::ST_MUL2;
          end else begin
            d_d     = prod_val;
            ga_d    = mag(n_q);
            gsa_d   = n_q[WIDTH-1];
            gb_d    = mag(prod_val);
            gsb_d   = prod_val[WIDTH-1];
            state_d = rag_pkg::ST_GCD;
          end
        end
      end
      rag_pkg::ST_GCD: begin
        if (cnt_q == '0) begin
          if (gb_q == '0) begin
            if (ga_q == '0) begin
              acc_num_d = n_q;
              acc_den_d = d_q;
              state_d   = rag_pkg::ST_DONE;
            end else begin
              state_d = rag_pkg::ST_DIVN;
            end
          end else begin
            hi_d  = '0;
            lo_d  = ga_q;
            y_d   = gb_q;
            cnt_d = cnt_q + CW'(1);
          end
        end else if (cnt_q != CntLast) begin
          hi_d  = hi_step;
          lo_d  = lo_step;
          cnt_d = cnt_q + CW'(1);
        end else begin
          // remainder takes the sign of the dividend
          ga_d  = gb_q;
          gsa_d = gsb_q;
          gb_d  = hi_q;
          gsb_d = gsa_q;
          cnt_d = '0;
        end
      end
      rag_pkg::ST_DIVN, rag_pkg::ST_DIVD: begin
        if (cnt_q == '0) begin
          hi_d  = '0;
          y_d   = ga_q;
          cnt_d = cnt_q + CW'(1);
          if (state_q == rag_pkg::ST_DIVN) begin
            lo_d  = mag(n_q);
            neg_d = n_q[WIDTH-1] ^ gsa_q;
          end else begin
            lo_d  = mag(d_q);
            neg_d = d_q[WIDTH-1] ^ gsa_q;
          end
        end else if (cnt_q != CntLast) begin
          hi_d  = hi_step;
          lo_d  = lo_step;
          cnt_d = cnt_q + CW'(1);
        end else begin
          cnt_d = '0;
          ov_d  = ov_q | (!neg_q && lo_q[WIDTH-1]);
          if (state_q == rag_pkg::ST_DIVN) begin
            n_d     = prod_val;
            state_d = rag_pkg::ST_DIVD;
          end else begin
            acc_num_d = n_q;
            acc_den_d = prod_val;
            state_d   = rag_pkg::ST_DONE;
          end
        end
      end
      rag_pkg::ST_DONE: begin
        if (out_o.ready) begin
          state_d = rag_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rag_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rag_pkg::ST_IDLE;
      cnt_q     <= '0;
      acc_num_q <= '0;
      acc_den_q <= {{(WIDTH-1){1'b0}}, 1'b1};
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      acc_num_q <= acc_num_d;
      acc_den_q <= acc_den_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= in_i.func;
      an_q   <= an_w;
      ad_q   <= ad_fix;
      bn_q   <= bn_w;
      bd_q   <= bd_fix;
    end
    n_q   <= n_d;
    d_q   <= d_d;
    hi_q  <= hi_d;
    lo_q  <= lo_d;
    y_q   <= y_d;
    neg_q <= neg_d;
    ga_q  <= ga_d;
    gb_q  <= gb_d;
    gsa_q <= gsa_d;
    gsb_q <= gsb_d;
    ov_q  <= ov_d;
  end

  assign in_i.ready     = (state_q == rag_pkg::ST_IDLE);
  assign out_o.valid    = (state_q == rag_pkg::ST_DONE);
  assign out_o.res_num  = FW'($signed(acc_num_q));
  assign out_o.res_den  = FW'($signed(acc_den_q));
  assign out_o.overflow = ov_q;

  `ASSERT_ALWAYS(a_no_overlap, clk_i, rst_ni, !(in_i.ready && out_o.valid), "ready with result pending")
  `ASSERT_ALWAYS(a_cnt_range, clk_i, rst_ni, cnt_q <= CntLast, "step counter out of range")
  `ASSERT_NEXT(a_busy_after_beat, clk_i, rst_ni, accept, !in_i.ready, "ready right after a beat")

endmodule
